### sv/ffa_pkg.sv
package ffa_pkg;

  // Memory and table geometry
  localparam int MEM_SIZE   = 1024;
  localparam int MAX_BLOCKS = 64;

  localparam int ADDR_W = $clog2(MEM_SIZE);
  localparam int SIZE_W = $clog2(MEM_SIZE + 1);
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

  // Field widths of the request and response items
  localparam int REQ_W    = 11;
  localparam int FADDR_W  = 10;
  localparam int BSTART_W = 10;
  localparam int STATUS_W = 2;

  // Width for size and address compares without overflow
  localparam int W_SUM = ((SIZE_W > REQ_W) ? SIZE_W : REQ_W) + 1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_HEAD,
    S_MARK,
    S_APPEND,
    S_RESP
  } ffa_state_e;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NEXT,
    RD_LAST,
    RD_SHIFT
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT,
    WR_REMAIN,
    WR_HEAD,
    WR_MARK,
    WR_APPEND
  } wr_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_FOUND,
    RES_END
  } res_sel_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              used;
  } ffa_entry_t;

  localparam ffa_entry_t ENTRY_RESET = '{
    start: '0,
    size:  SIZE_W'(MEM_SIZE),
    used:  1'b0
  };

  // Controller to datapath
  typedef struct packed {
    logic     start;
    logic     scan;
    logic     capture;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    logic     set_res;
    res_sel_e res_sel;
    status_e  res_status;
    logic     load_out;
  } ffa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic scan_end;
    logic hit;
    logic split;
    logic full;
    logic fits;
    logic shift_more;
    logic out_free;
  } ffa_stat_t;

endpackage

### sv/ffa_if.sv
interface ffa_req_if;
  import ffa_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [REQ_W-1:0]   request_size;
  logic [FADDR_W-1:0] free_address;

  modport source (output valid, output opcode, output request_size, output free_address,
                  input ready);
  modport sink (input valid, input opcode, input request_size, input free_address,
                output ready);
endinterface

interface ffa_rsp_if;
  import ffa_pkg::*;

  logic                valid;
  logic                ready;
  logic [BSTART_W-1:0] block_start;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output block_start, output status, input ready);
  modport sink (input valid, input block_start, input status, output ready);
endinterface

### sv/first_fit_block_allocator_top.sv
// First-fit block allocator. The block keeps an ordered table of up to
// MAX_BLOCKS blocks (start, size, allocated) that tiles MEM_SIZE words; after
// reset it holds one free block covering all memory. An allocate item takes
// the first free block large enough, splitting off the free remainder right
// after it (later entries shift up), or appends a block after the last one
// when it still fits; a free item marks the allocated block starting at the
// address as free, with no coalescing. Each item gives exactly one response
// item with block_start and status (ok, no_space, table_full, not_found).
// Timing: the table sits in a memory with one read port and one write port,
// so the scan handles one entry per cycle. An item is accepted, its scan
// visits the entries in order, on a split the later entries shift up and the
// free remainder is written, the table is written where it changes, and the
// response is loaded, waiting while the output register still holds an
// unaccepted item. The next request item is accepted once the block is
// back in idle, even while the previous response item still waits in the
// output register. No clearing pass is needed after reset.
module first_fit_block_allocator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffa_req_if.sink    req_i,
  ffa_rsp_if.source  rsp_o
);
  import ffa_pkg::*;

  ffa_cmd_t  cmd;
  ffa_stat_t stat;
  logic      req_ready;

  // Sequencer: accept, scan, shift, update, respond
  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // Table memory, compares and the output register
  ffa_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_opcode_i      (req_i.opcode),
    .req_size_i        (req_i.request_size),
    .req_addr_i        (req_i.free_address),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_block_start_o (rsp_o.block_start),
    .rsp_status_o      (rsp_o.status),
    .cmd_i             (cmd),
    .stat_o            (stat)
  );

endmodule

### sv/ffa_ctrl.sv
module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  ffa_pkg::ffa_stat_t stat_i,
  output ffa_pkg::ffa_cmd_t  cmd_o
);
  import ffa_pkg::*;

  ffa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        priority if (stat_i.zero_req && !stat_i.is_free) begin
          state_d = S_RESP;
        end else if (stat_i.scan_end) begin
          if (!stat_i.is_free && stat_i.fits && !stat_i.full) state_d = S_APPEND;
          else state_d = S_RESP;
        end else if (stat_i.hit) begin
          if (stat_i.is_free || !stat_i.split) state_d = S_MARK;
          else if (stat_i.full) state_d = S_RESP;
          else state_d = S_SHIFT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SHIFT: begin
        if (!stat_i.shift_more) state_d = S_HEAD;
      end
      S_HEAD:   state_d = S_RESP;
      S_MARK:   state_d = S_RESP;
      S_APPEND: state_d = S_RESP;
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_NEXT;
    cmd_o.wr_sel     = WR_NONE;
    cmd_o.res_sel    = RES_ZERO;
    cmd_o.res_status = ST_OK;
    req_ready_o      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.rd_sel = RD_ZERO;
        cmd_o.start  = req_valid_i;
      end
      S_SCAN: begin
        priority if (stat_i.zero_req && !stat_i.is_free) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NO_SPACE;
        end else if (stat_i.scan_end) begin
          // APPEND sets its own result
          cmd_o.set_res = 1'b1;
          priority if (stat_i.is_free) cmd_o.res_status = ST_NOT_FOUND;
          else if (!stat_i.fits)       cmd_o.res_status = ST_NO_SPACE;
          else if (stat_i.full)        cmd_o.res_status = ST_TABLE_FULL;
          else                         cmd_o.res_status = ST_OK;
        end else if (stat_i.hit) begin
          cmd_o.capture = 1'b1;
          cmd_o.rd_sel  = RD_LAST;
          if (!stat_i.is_free && stat_i.split && stat_i.full) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ST_TABLE_FULL;
          end
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.rd_sel = RD_SHIFT;
        cmd_o.wr_sel = stat_i.shift_more ? WR_SHIFT : WR_REMAIN;
      end
      S_HEAD: begin
        cmd_o.wr_sel  = WR_HEAD;
        cmd_o.set_res = 1'b1;
        cmd_o.res_sel = RES_FOUND;
      end
      S_MARK: begin
        cmd_o.wr_sel  = WR_MARK;
        cmd_o.set_res = 1'b1;
        cmd_o.res_sel = stat_i.is_free ? RES_ZERO : RES_FOUND;
      end
      S_APPEND: begin
        cmd_o.wr_sel  = WR_APPEND;
        cmd_o.set_res = 1'b1;
        cmd_o.res_sel = RES_END;
      end
      S_RESP: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
        cmd_o.rd_sel = RD_ZERO;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_shift_only_on_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && state_d == S_SHIFT) |-> (stat_i.split && !stat_i.full))
    else $error("shift started without a legal split");

  a_resp_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HEAD || state_q == S_MARK || state_q == S_APPEND) |=> state_q == S_RESP)
    else $error("table update not followed by response");

  a_leave_resp_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && state_d == S_IDLE) |-> cmd_o.load_out)
    else $error("response dropped");
`endif

endmodule

### sv/ffa_dpath.sv
module ffa_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_opcode_i,
  input  logic [ffa_pkg::REQ_W-1:0]    req_size_i,
  input  logic [ffa_pkg::FADDR_W-1:0]  req_addr_i,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic [ffa_pkg::BSTART_W-1:0] rsp_block_start_o,
  output logic [ffa_pkg::STATUS_W-1:0] rsp_status_o,
  input  ffa_pkg::ffa_cmd_t            cmd_i,
  output ffa_pkg::ffa_stat_t           stat_o
);
  import ffa_pkg::*;

  ffa_entry_t mem [MAX_BLOCKS];

  // Request
  logic               op_free_q;
  logic [REQ_W-1:0]   req_q;
  logic [FADDR_W-1:0] faddr_q;

  // Table bookkeeping
  logic [CNT_W-1:0]  count_q;
  logic [SIZE_W-1:0] end_q;
  logic              e0_init_q;
  logic              e0_sel_q;

  // Scan and shift
  logic [CNT_W-1:0]  ptr_q;
  logic [CNT_W-1:0]  wptr_q;
  logic [IDX_W-1:0]  fidx_q;
  logic [ADDR_W-1:0] fstart_q;
  logic [SIZE_W-1:0] fsize_q;
  ffa_entry_t        rdata_q;
  ffa_entry_t        rd_ent;

  // Result and output register
  logic [BSTART_W-1:0] res_start_q;
  status_e             res_status_q;
  logic                out_valid_q;
  logic [BSTART_W-1:0] out_start_q;
  status_e             out_status_q;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  ffa_entry_t       wdata;
  logic             wr_en;
  logic             grow;
  logic [W_SUM-1:0] req_w;
  logic [W_SUM-1:0] size_w;

  // Entry 0 reads as its reset value until first written
  assign rd_ent = e0_sel_q ? ENTRY_RESET : rdata_q;
  assign req_w  = W_SUM'(req_q);
  assign size_w = W_SUM'(rd_ent.size);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ZERO:  rd_addr = '0;
      RD_NEXT:  rd_addr = IDX_W'(ptr_q + CNT_W'(1));
      RD_LAST:  rd_addr = IDX_W'(count_q - CNT_W'(1));
      RD_SHIFT: rd_addr = IDX_W'(wptr_q - CNT_W'(2));
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = fidx_q;
    wdata   = '{start: fstart_q, size: fsize_q, used: !op_free_q};
    unique case (cmd_i.wr_sel)
      WR_NONE: wr_en = 1'b0;
      WR_SHIFT: begin
        wr_addr = wptr_q[IDX_W-1:0];
        wdata   = rd_ent;
      end
      WR_REMAIN: begin
        wr_addr = fidx_q + IDX_W'(1);
        wdata   = '{start: ADDR_W'(W_SUM'(fstart_q) + req_w),
                    size:  SIZE_W'(W_SUM'(fsize_q) - req_w),
                    used:  1'b0};
      end
      WR_HEAD: begin
        wdata = '{start: fstart_q, size: SIZE_W'(req_q), used: 1'b1};
      end
      WR_MARK: ;
      WR_APPEND: begin
        wr_addr = count_q[IDX_W-1:0];
        wdata   = '{start: ADDR_W'(end_q), size: SIZE_W'(req_q), used: 1'b1};
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign grow = (cmd_i.wr_sel == WR_HEAD) || (cmd_i.wr_sel == WR_APPEND);

  // Table memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CNT_W'(1);
      end_q     <= SIZE_W'(MEM_SIZE);
      e0_init_q <= 1'b1;
      e0_sel_q  <= 1'b1;
      ptr_q     <= '0;
      wptr_q    <= '0;
    end else begin
      e0_sel_q <= e0_init_q && (rd_addr == '0);
      if (wr_en && wr_addr == '0) e0_init_q <= 1'b0;
      if (grow) count_q <= count_q + CNT_W'(1);
      if (cmd_i.wr_sel == WR_APPEND) end_q <= SIZE_W'(W_SUM'(end_q) + req_w);
      if (cmd_i.start) ptr_q <= '0;
      else if (cmd_i.scan) ptr_q <= ptr_q + CNT_W'(1);
      if (cmd_i.capture) wptr_q <= count_q;
      else if (cmd_i.wr_sel == WR_SHIFT) wptr_q <= wptr_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_free_q <= req_opcode_i;
      req_q     <= req_size_i;
      faddr_q   <= req_addr_i;
    end
    if (cmd_i.capture) begin
      fidx_q   <= ptr_q[IDX_W-1:0];
      fstart_q <= rd_ent.start;
      fsize_q  <= rd_ent.size;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      unique case (cmd_i.res_sel)
        RES_ZERO:  res_start_q <= '0;
        RES_FOUND: res_start_q <= BSTART_W'(fstart_q);
        RES_END:   res_start_q <= BSTART_W'(end_q);
        default:   res_start_q <= '0;
      endcase
    end
    if (cmd_i.load_out) begin
      out_start_q  <= res_start_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_block_start_o = out_start_q;
  assign rsp_status_o      = out_status_q;

  always_comb begin
    stat_o.is_free    = op_free_q;
    stat_o.zero_req   = (req_q == '0);
    stat_o.scan_end   = (ptr_q == count_q);
    stat_o.hit        = (ptr_q != count_q) &&
                        (op_free_q ? (rd_ent.used &&
                                      W_SUM'(rd_ent.start) == W_SUM'(faddr_q))
                                   : (!rd_ent.used && size_w >= req_w));
    stat_o.split      = (size_w > req_w);
    stat_o.full       = (count_q >= CNT_W'(MAX_BLOCKS));
    stat_o.fits       = (W_SUM'(end_q) + req_w <= W_SUM'(MEM_SIZE));
    stat_o.shift_more = (wptr_q > CNT_W'(fidx_q) + CNT_W'(1));
    stat_o.out_free   = !out_valid_q || rsp_ready_i;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_end_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    W_SUM'(end_q) <= W_SUM'(MEM_SIZE))
    else $error("table end beyond memory");

  a_grow_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grow |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("block count did not advance by one");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || rsp_ready_i))
    else $error("output register overwritten");
`endif

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ffa_pkg::*;

  // Number of random items that follow the directed part
  localparam int unsigned N_RANDOM = 1530;
  // Worst case cycles for one item inside the block, taken with margin
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_BLOCKS + 8;

  // One request item as the driver puts it on the bus
  typedef struct {
    opcode_e              op;
    logic [REQ_W-1:0]     size;
    logic [FADDR_W-1:0]   addr;
  } alloc_req_t;

  // One response item as the block should return it
  typedef struct {
    logic [BSTART_W-1:0]  start;
    status_e              status;
  } alloc_rsp_t;

  // One entry of the shadow block table
  typedef struct {
    int unsigned base;
    int unsigned len;
    bit          taken;
  } blk_rec_t;

  logic clk_i;
  logic rst_ni;

  ffa_req_if req_bus();
  ffa_rsp_if rsp_bus();

  first_fit_block_allocator_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow copy of the allocator state
  blk_rec_t    blk_tab [MAX_BLOCKS];
  int unsigned blk_cnt;

  // Items waiting for the driver, and responses the block still owes
  alloc_req_t  pend_q [$];
  alloc_rsp_t  owed_rsp_q [$];

  int unsigned err_cnt;
  logic        req_fire;
  int unsigned req_gap;
  int unsigned rsp_stall;
  bit          req_calm;
  bit          rsp_calm;

  // ---------------------------------------------------------------------------
  // Shadow allocator
  // ---------------------------------------------------------------------------

  // First-fit allocate: split a larger block and insert the free remainder
  // right after it; with no fitting free block, append after the last one.
  function automatic status_e shadow_alloc(input int unsigned want, output int unsigned at);
    int unsigned j;
    int unsigned tail;
    at = 0;
    if (want == 0) return ST_NO_SPACE;
    for (int unsigned i = 0; i < blk_cnt; i++) begin
      if (!blk_tab[i].taken && blk_tab[i].len >= want) begin
        if (blk_tab[i].len > want) begin
          // The split needs a new entry; a full table stops the scan here
          if (blk_cnt >= MAX_BLOCKS) return ST_TABLE_FULL;
          for (j = blk_cnt; j > i + 1; j--) blk_tab[j] = blk_tab[j - 1];
          blk_tab[i + 1].base  = blk_tab[i].base + want;
          blk_tab[i + 1].len   = blk_tab[i].len - want;
          blk_tab[i + 1].taken = 1'b0;
          blk_tab[i].len = want;
          blk_cnt++;
        end
        blk_tab[i].taken = 1'b1;
        at = blk_tab[i].base;
        return ST_OK;
      end
    end
    tail = blk_tab[blk_cnt - 1].base + blk_tab[blk_cnt - 1].len;
    if (tail + want <= MEM_SIZE) begin
      if (blk_cnt >= MAX_BLOCKS) return ST_TABLE_FULL;
      blk_tab[blk_cnt].base  = tail;
      blk_tab[blk_cnt].len   = want;
      blk_tab[blk_cnt].taken = 1'b1;
      blk_cnt++;
      at = tail;
      return ST_OK;
    end
    return ST_NO_SPACE;
  endfunction

  // Release the first allocated block that starts at the address; no merging
  function automatic status_e shadow_free(input int unsigned addr);
    for (int unsigned i = 0; i < blk_cnt; i++) begin
      if (blk_tab[i].taken && blk_tab[i].base == addr) begin
        blk_tab[i].taken = 1'b0;
        return ST_OK;
      end
    end
    return ST_NOT_FOUND;
  endfunction

  // Apply one accepted request item to the shadow state, give its response
  function automatic alloc_rsp_t predict_response(input alloc_req_t it);
    alloc_rsp_t  r;
    int unsigned at;
    at = 0;
    if (it.op == OP_ALLOC) r.status = shadow_alloc(int'(it.size), at);
    else                   r.status = shadow_free(int'(it.addr));
    r.start = BSTART_W'(at);
    return r;
  endfunction

  // Pause length: mostly none or short, now and then long; none in calm stretches
  function automatic int unsigned pick_pause(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90)         return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void queue_item(input opcode_e op, input int unsigned size,
                                     input int unsigned addr);
    alloc_req_t it;
    it.op   = op;
    it.size = REQ_W'(size);
    it.addr = FADDR_W'(addr);
    pend_q = {pend_q, it};
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Request driver: change inputs at the falling edge. Once the current item
  // was taken at the last rising edge (or nothing is on the bus), either hold
  // off for a gap or present the next pending item.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_fire) begin
      if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
      if (req_gap > 0) begin
        req_gap--;
        req_bus.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        alloc_req_t it;
        it = pend_q.pop_front();
        req_bus.opcode       <= it.op;
        req_bus.request_size <= it.size;
        req_bus.free_address <= it.addr;
        req_bus.valid        <= 1'b1;
        req_gap = pick_pause(req_calm);
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Response back-pressure: stall ready for random stretches
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
        rsp_stall = pick_pause(rsp_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample at the rising edge. Check a completed response item
  // against the oldest owed response, then predict for a completed request.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    alloc_rsp_t want;
    alloc_rsp_t pred;
    alloc_req_t got_req;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (owed_rsp_q.size() == 0) begin
          $error("response item with none owed: block_start %0d status %0d",
                 rsp_bus.block_start, rsp_bus.status);
          err_cnt++;
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp_bus.block_start !== want.start) begin
            $error("block_start: expected %0d, got %0d", want.start, rsp_bus.block_start);
            err_cnt++;
          end
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %s, got %0d", want.status.name(), rsp_bus.status);
            err_cnt++;
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        got_req.op   = opcode_e'(req_bus.opcode);
        got_req.size = req_bus.request_size;
        got_req.addr = req_bus.free_address;
        pred = predict_response(got_req);
        owed_rsp_q = {owed_rsp_q, pred};
      end
    end
    req_fire <= rst_ni && req_bus.valid && req_bus.ready;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    alloc_req_t  it;
    int unsigned pool [$];
    int unsigned r;
    int unsigned s;

    // Hold every input at a known value from time zero
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.opcode       = OP_ALLOC;
    req_bus.request_size = '0;
    req_bus.free_address = '0;
    rsp_bus.ready        = 1'b0;
    req_fire             = 1'b0;
    req_gap              = 0;
    rsp_stall            = 0;
    req_calm             = 1'b0;
    rsp_calm             = 1'b0;
    err_cnt              = 0;

    // Shadow state after reset: one free block over all of memory
    foreach (blk_tab[i]) blk_tab[i] = '{base: 0, len: 0, taken: 1'b0};
    blk_tab[0].len = MEM_SIZE;
    blk_cnt = 1;

    // Directed part: zero and oversized sizes, whole-memory exact fit, full
    // memory, double free and unmatched free, split, exact fit into a freed
    // hole, first fit skipping a too-small hole. Ignored fields carry zero, all ones or other values.
    queue_item(OP_ALLOC, 0,    0);
    queue_item(OP_ALLOC, 2047, 1023);
    queue_item(OP_ALLOC, 1025, 0);
    queue_item(OP_ALLOC, 1024, 1023);
    queue_item(OP_ALLOC, 1,    0);
    queue_item(OP_FREE,  2047, 0);
    queue_item(OP_FREE,  0,    0);
    queue_item(OP_FREE,  0,    1023);
    queue_item(OP_ALLOC, 100,  0);
    queue_item(OP_ALLOC, 200,  512);
    queue_item(OP_FREE,  2047, 100);
    queue_item(OP_ALLOC, 150,  0);
    queue_item(OP_ALLOC, 50,   0);
    queue_item(OP_ALLOC, 724,  0);
    queue_item(OP_ALLOC, 1,    0);
    queue_item(OP_FREE,  0,    300);
    queue_item(OP_FREE,  0,    250);
    queue_item(OP_ALLOC, 60,   0);
    queue_item(OP_ALLOC, 50,   0);
    queue_item(OP_ALLOC, 1024, 0);
    queue_item(OP_FREE,  1024, 512);
    queue_item(OP_FREE,  0,    360);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Random part: generate a little ahead of the driver so that sizes and
    // addresses follow the current table. Small sizes fill the table up to
    // its limit; exact-fit sizes and real block starts keep reaching the
    // ok paths once it is full.
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      do begin
        @(posedge clk_i);
        #0.25;
      end while (pend_q.size() >= 2);
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      pool.delete();
      if (r < 60) begin
        it.op   = OP_ALLOC;
        it.addr = FADDR_W'($urandom);
        for (int unsigned i = 0; i < blk_cnt; i++)
          if (!blk_tab[i].taken) pool = {pool, blk_tab[i].len};
        if (s < 55)                           it.size = REQ_W'($urandom_range(1, 24));
        else if (s < 72 && pool.size() > 0)   it.size = REQ_W'(pool[$urandom_range(0, pool.size() - 1)]);
        else if (s < 82)                      it.size = REQ_W'($urandom_range(1, 200));
        else if (s < 92)                      it.size = REQ_W'($urandom_range(0, 2047));
        else if (s < 96)                      it.size = '0;
        else                                  it.size = REQ_W'($urandom_range(1024, 2047));
      end else begin
        it.op   = OP_FREE;
        it.size = REQ_W'($urandom);
        for (int unsigned i = 0; i < blk_cnt; i++)
          if (blk_tab[i].taken == (s < 70)) pool = {pool, blk_tab[i].base};
        if (s < 85 && pool.size() > 0) it.addr = FADDR_W'(pool[$urandom_range(0, pool.size() - 1)]);
        else                           it.addr = FADDR_W'($urandom_range(0, 1023));
      end
      pend_q = {pend_q, it};
    end

    // Drain: every item taken, every response back, then let the block settle
    while (pend_q.size() > 0 || req_bus.valid || owed_rsp_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
